@@ sv/assert_macros.svh @@
// Assertion macros shared by the glyph cell rasterizer modules.
// No dependencies; the assertion bodies are dropped when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define GCR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("gcr: assertion failed");
// Check that a condition leads to a consequence in the next cycle.
`define GCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gcr: next-cycle assertion failed");
`else
`define GCR_ASSERT(lbl, clk, rstn, prop)
`define GCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/gcr_pkg.sv @@
// Shared types, constants and the 5x7 font table for the glyph cell rasterizer.
// No dependencies; used by every module of the block.
package gcr_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;
    localparam int unsigned FONT_ENTRIES = 95;

    // Cell sequencing: column 0 is the spacing column, 1..5 the glyph columns.
    localparam logic [2:0] COL_SPACING = 3'd0;
    localparam logic [2:0] COL_LAST    = 3'd5;
    localparam logic [2:0] ROW_LAST    = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEXT_COLOR = 2'd0;
    localparam logic [1:0] CFG_BACK_COLOR = 2'd1;
    localparam logic [1:0] CFG_SCALE      = 2'd2;

    typedef logic [6:0] font_idx_t;
    // Byte 4 is font column 0, byte 0 is font column 4.
    typedef logic [4:0][7:0] glyph_t;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
    } in_item_t;

    typedef struct packed {
        logic [15:0] x_first;
        logic [15:0] x_last;
        logic [15:0] y_first;
        logic [15:0] y_last;
        logic [15:0] fill_color;
        logic        last_cell;
    } out_item_t;

    typedef struct packed {
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        glyph_t      glyph;
    } job_t;

    typedef struct packed {
        logic [15:0] text_color;
        logic [15:0] back_color;
        logic [4:0]  scale;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam glyph_t FONT_ROM [FONT_ENTRIES] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414147C, 40'h7C08040408, 40'h4854545420, 40'h043E444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0836414100, 40'h00007F0000, 40'h0041413608, 40'h08082A1C08
    };

endpackage

@@ sv/glyph_cell_rasterizer.sv @@
// Glyph cell rasterizer: turns one character transaction (code and top-left
// position) into 48 square fill rectangles, one per cycle on the m_ channel
// while m_ready allows: eight background cells of the spacing column, then
// glyph columns left to right, each top to bottom, from the back-end cell
// counter. From idle, a taken character passes the job queue and back-end
// walk registers before the output register. The front end classifies and
// fetches the font entry; the job queue parks up to QUEUE_DEPTH characters
// ahead, so s_ready stays high while it has room. The user must write the
// registers (text colour, background colour, scale) through the cfg_ channel
// only while no character is in flight; the block does not enforce this.
//
// Top level: configuration registers, front end, job queue and back end.
// Depends on gcr_pkg, gcr_front, gcr_fifo and gcr_back.
module glyph_cell_rasterizer #(
    parameter int unsigned QUEUE_DEPTH = gcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  gcr_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gcr_pkg::out_item_t  m_data
);

    gcr_pkg::cfg_t       cfg_reg;
    gcr_pkg::q_status_t  q_status;
    gcr_pkg::job_t       push_job;
    gcr_pkg::job_t       pop_job;
    logic                q_push;
    logic                q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.text_color <= 16'hFFFF;
            cfg_reg.back_color <= 16'h0000;
            cfg_reg.scale      <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            // Drop writes to indexes beyond the register list.
            unique case (cfg_index)
                gcr_pkg::CFG_TEXT_COLOR: cfg_reg.text_color <= cfg_data;
                gcr_pkg::CFG_BACK_COLOR: cfg_reg.back_color <= cfg_data;
                gcr_pkg::CFG_SCALE:      cfg_reg.scale      <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    gcr_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    gcr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    gcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ sv/gcr_front.sv @@
// Front end: takes character transactions, maps the code to a font entry and
// fetches its glyph. Depends on gcr_pkg.
module gcr_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  gcr_pkg::in_item_t   s_data,
    input  gcr_pkg::q_status_t  q_status,
    output logic                q_push,
    output gcr_pkg::job_t       q_job
);

    logic                 printable;
    gcr_pkg::font_idx_t   font_idx;

    // Anything outside the printable range draws as space (entry zero).
    assign printable = (s_data.char_code >= gcr_pkg::FIRST_CODE) &&
                       (s_data.char_code <= gcr_pkg::LAST_CODE);
    assign font_idx  = printable ? 7'(s_data.char_code - gcr_pkg::FIRST_CODE) : '0;

    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready;

    assign q_job.x_pos = s_data.x_pos;
    assign q_job.y_pos = s_data.y_pos;
    assign q_job.glyph = gcr_pkg::FONT_ROM[font_idx];

endmodule

@@ sv/gcr_fifo.sv @@
// Short job queue between front and back end of the rasterizer.
// Depends on gcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gcr_fifo #(
    parameter int unsigned DEPTH = gcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  gcr_pkg::job_t       push_job,
    input  logic                pop,
    output gcr_pkg::job_t       pop_job,
    output gcr_pkg::q_status_t  status
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gcr_pkg::job_t     slot_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `GCR_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `GCR_ASSERT_NEXT(a_push_fills, aclk, aresetn, push && !pop && count_reg == CNT_W'(DEPTH - 1), status.full)

endmodule

@@ sv/gcr_back.sv @@
// Back end: walks the 48 cells of a character and drives the output register, one
// fill rectangle per cycle unless stalled. Depends on gcr_pkg, assert_macros.svh.
`include "assert_macros.svh"

module gcr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  gcr_pkg::cfg_t       cfg,
    input  gcr_pkg::q_status_t  q_status,
    input  gcr_pkg::job_t       q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output gcr_pkg::out_item_t  m_data
);

    logic                busy_reg, busy_next;
    logic [2:0]          col_reg, col_next;
    logic [2:0]          row_reg, row_next;
    logic [15:0]         px_reg, px_next;
    logic [15:0]         py_reg, py_next;
    logic [15:0]         ybase_reg, ybase_next;
    gcr_pkg::glyph_t     glyph_reg, glyph_next;
    logic                m_valid_reg, m_valid_next;
    gcr_pkg::out_item_t  m_data_reg, m_data_next;

    logic        out_free;
    logic        emit;
    logic        cell_last;
    logic        load;
    logic [15:0] step;
    logic [7:0]  col_byte;
    logic        pixel_on;

    assign step      = {11'd0, cfg.scale};
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;
    assign cell_last = (col_reg == gcr_pkg::COL_LAST) && (row_reg == gcr_pkg::ROW_LAST);
    assign load      = !q_status.empty && (!busy_reg || (emit && cell_last));
    assign q_pop     = load;

    // Glyph column c of the walk is font column 5-c, stored in byte c-1.
    always_comb begin
        case (col_reg)
            3'd1:    col_byte = glyph_reg[0];
            3'd2:    col_byte = glyph_reg[1];
            3'd3:    col_byte = glyph_reg[2];
            3'd4:    col_byte = glyph_reg[3];
            3'd5:    col_byte = glyph_reg[4];
            default: col_byte = 8'h00;
        endcase
    end

    // Row r shows bit 7-r of the column byte.
    assign pixel_on = col_byte[~row_reg];

    always_comb begin
        busy_next    = busy_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        ybase_next   = ybase_reg;
        glyph_next   = glyph_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next           = 1'b1;
            m_data_next.x_first    = px_reg;
            m_data_next.x_last     = px_reg + step - 16'd1;
            m_data_next.y_first    = py_reg;
            m_data_next.y_last     = py_reg + step - 16'd1;
            m_data_next.fill_color = pixel_on ? cfg.text_color : cfg.back_color;
            m_data_next.last_cell  = cell_last;
            // Advance down the column, then across to the next one.
            if (row_reg == gcr_pkg::ROW_LAST) begin
                row_next = '0;
                col_next = col_reg + 3'd1;
                px_next  = px_reg + step;
                py_next  = ybase_reg;
            end else begin
                row_next = row_reg + 3'd1;
                py_next  = py_reg + step;
            end
            // Park the walk at the spacing column once the character is done.
            if (cell_last) begin
                busy_next = 1'b0;
                col_next  = gcr_pkg::COL_SPACING;
                row_next  = '0;
            end
        end

        if (load) begin
            busy_next  = 1'b1;
            col_next   = gcr_pkg::COL_SPACING;
            row_next   = '0;
            px_next    = q_job.x_pos;
            py_next    = q_job.y_pos;
            ybase_next = q_job.y_pos;
            glyph_next = q_job.glyph;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
        px_reg     <= px_next;
        py_reg     <= py_next;
        ybase_reg  <= ybase_next;
        glyph_reg  <= glyph_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GCR_ASSERT(a_idle_at_origin, aclk, aresetn, busy_reg || (col_reg == gcr_pkg::COL_SPACING && row_reg == '0))
    `GCR_ASSERT(a_col_range, aclk, aresetn, col_reg <= gcr_pkg::COL_LAST)
    `GCR_ASSERT_NEXT(a_spacing_back, aclk, aresetn, emit && col_reg == gcr_pkg::COL_SPACING, m_data_reg.fill_color == $past(cfg.back_color))
    `GCR_ASSERT_NEXT(a_last_ends_char, aclk, aresetn, emit && cell_last && q_status.empty, !busy_reg)

endmodule

@@ bench/tb.sv @@
// Testbench for glyph_cell_rasterizer: drives characters and register writes, predicts the
// 48 fill rectangles of every character and compares them field by field as they leave.
// Depends on gcr_pkg and the glyph_cell_rasterizer RTL.
`timescale 1ns / 1ps

module tb;

    import gcr_pkg::*;

    localparam int          RECTS_PER_CHAR = 48;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          TAIL_CYCLES    = 100;
    localparam int          CYCLE_LIMIT    = 2_000_000;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;

    localparam logic [7:0]  EDGE_CODES [11] = '{8'd0, 8'd31, 8'd32, 8'd33, 8'd35, 8'd65,
                                                8'd103, 8'd126, 8'd127, 8'd128, 8'd255};
    localparam logic [15:0] EDGE_POS [5]    = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                                                16'hFFFC};

    class glyph_rect_tracker;
        out_item_t   rects_due[$];
        logic [15:0] text_r;
        logic [15:0] back_r;
        logic [4:0]  scale_r;
        logic [39:0] glyphs [95];
        int          errors;

        function new();
            // Font columns 0..4 from the top byte down.
            glyphs = '{
                40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
                40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
                40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
                40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
                40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
                40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
                40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
                40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
                40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
                40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
                40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
                40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
                40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
                40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
                40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
                40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
                40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
                40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
                40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
                40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
                40'h7C14141408, 40'h081414147C, 40'h7C08040408, 40'h4854545420,
                40'h043E444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
                40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0836414100,
                40'h00007F0000, 40'h0041413608, 40'h08082A1C08
            };
            text_r  = 16'hFFFF;
            back_r  = 16'h0000;
            scale_r = 5'd1;
            errors  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_TEXT_COLOR: text_r  = val;
                CFG_BACK_COLOR: back_r  = val;
                CFG_SCALE:      scale_r = val[4:0];
                default: ;
            endcase
        endfunction

        function void add_rect(logic [15:0] x, logic [15:0] y, logic [15:0] colour, bit last);
            out_item_t r;
            r.x_first    = x;
            r.x_last     = x + {11'd0, scale_r} - 16'd1;
            r.y_first    = y;
            r.y_last     = y + {11'd0, scale_r} - 16'd1;
            r.fill_color = colour;
            r.last_cell  = last;
            rects_due.push_back(r);
        endfunction

        // Spacing column first, then glyph columns 4 down to 0, each bit 7 down to 0.
        function void note_char(in_item_t ch);
            logic [7:0]  code;
            logic [7:0]  line;
            logic [15:0] step;
            logic [15:0] px;
            int          k;
            code = ch.char_code;
            if (code < FIRST_CODE || code > LAST_CODE) begin
                code = FIRST_CODE;
            end
            step = {11'd0, scale_r};
            k = 0;
            for (int row = 0; row < 8; row++) begin
                add_rect(ch.x_pos, ch.y_pos + 16'(row) * step, back_r,
                         k == RECTS_PER_CHAR - 1);
                k++;
            end
            for (int col = 4; col >= 0; col--) begin
                line = glyphs[code - FIRST_CODE][39 - 8 * col -: 8];
                px   = ch.x_pos + 16'(5 - col) * step;
                for (int b = 7; b >= 0; b--) begin
                    add_rect(px, ch.y_pos + 16'(7 - b) * step, line[b] ? text_r : back_r,
                             k == RECTS_PER_CHAR - 1);
                    k++;
                end
            end
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_rect(out_item_t got);
            out_item_t want;
            if (rects_due.size() == 0) begin
                $display("%0t: rectangle with none pending, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = rects_due.pop_front();
            compare("x_first", want.x_first, got.x_first);
            compare("x_last", want.x_last, got.x_last);
            compare("y_first", want.y_first, got.y_first);
            compare("y_last", want.y_last, got.y_last);
            compare("fill_color", want.fill_color, got.fill_color);
            compare("last_cell", {15'd0, want.last_cell}, {15'd0, got.last_cell});
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    glyph_rect_tracker tracker = new();
    bit idle_on;
    bit hold_req;
    int cycles;

    glyph_cell_rasterizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_rect(m_data);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: random back-pressure, plus one long hold on request.
    initial begin : result_ready
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                stall = gap_len();
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    task automatic send_char(input in_item_t ch);
        s_valid <= 1'b1;
        s_data  <= ch;
        do @(posedge aclk); while (!s_ready);
        tracker.note_char(ch);
    endtask

    task automatic pause_sender(input bit allow);
        int n;
        n = allow ? gap_len() : 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, val);
    endtask

    // Drain every pending rectangle before touching the registers.
    task automatic configure(input logic [15:0] txt, input logic [15:0] bk,
                             input logic [15:0] sc, input bit poke_unused);
        s_valid <= 1'b0;
        while (tracker.rects_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        write_reg(CFG_TEXT_COLOR, txt);
        write_reg(CFG_BACK_COLOR, bk);
        write_reg(CFG_SCALE, sc);
        if (poke_unused) begin
            write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t random_char();
        in_item_t ch;
        ch.char_code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 126))
                                                   : 8'($urandom_range(0, 255));
        ch.x_pos = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 40))
                                               : 16'($urandom_range(0, 65535));
        ch.y_pos = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 40))
                                               : 16'($urandom_range(0, 65535));
        return ch;
    endfunction

    initial begin : stimulus
        logic [4:0]  sc;
        logic [15:0] txt;
        logic [15:0] bk;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TEXT_COLOR;
        cfg_data  = 16'h0000;
        s_valid   = 1'b0;
        s_data    = '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        cycles    = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: out-of-range codes, full-column glyphs, wrapping corners.
        for (int i = 0; i < 11; i++) begin
            send_char('{char_code: EDGE_CODES[i], x_pos: EDGE_POS[i % 5],
                        y_pos: EDGE_POS[(i + 2) % 5]});
            pause_sender(1'b1);
        end

        // Zero scale: all rectangles of a character start at one spot, each ending one below its start.
        configure(16'h0000, 16'hFFFF, 16'hFFE0, 1'b1);
        send_char('{char_code: 8'd35, x_pos: 16'h1234, y_pos: 16'hFFFF});
        send_char('{char_code: 8'd87, x_pos: 16'h0000, y_pos: 16'h0000});

        // Largest scale the register holds: positions wrap past the top.
        configure(16'hFFFF, 16'h0000, 16'h001F, 1'b0);
        send_char('{char_code: 8'd64, x_pos: 16'hFF80, y_pos: 16'hFFA0});
        send_char('{char_code: 8'd200, x_pos: 16'hFFFF, y_pos: 16'h8000});

        for (int p = 0; p < 6; p++) begin
            txt = 16'($urandom_range(0, 65535));
            bk  = 16'($urandom_range(0, 65535));
            case (p)
                0: sc = 5'd1;
                1: begin
                    sc  = 5'd16;
                    txt = 16'hFFFF;
                    bk  = 16'h0000;
                end
                2: sc = 5'($urandom_range(1, 16));
                3: sc = 5'd2;
                4: sc = 5'($urandom_range(0, 31));
                default: sc = 5'($urandom_range(1, 16));
            endcase
            configure(txt, bk, {11'($urandom_range(0, 2047)), sc}, p == 3);
            idle_on = (p != 2);
            for (int n = 0; n < 30; n++) begin
                // Hold the result side off while characters keep coming.
                if (p == 1 && n == 0) begin
                    hold_req = 1'b1;
                end
                send_char(random_char());
                pause_sender(idle_on && !(p == 1 && n < 10));
            end
        end

        s_valid <= 1'b0;
        while (tracker.rects_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ glyph_cell_rasterizer.f @@
+incdir+sv
sv/gcr_pkg.sv
sv/gcr_front.sv
sv/gcr_fifo.sv
sv/gcr_back.sv
sv/glyph_cell_rasterizer.sv
bench/tb.sv
